@@ rtl/grid_cell_consistency_updater_core_macros.svh @@
// ----------------------------------------------------------------------------
// grid cell consistency updater assertion macros
// concurrent assertion helpers clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_CONSISTENCY_UPDATER_CORE_MACROS_SVH
`define GRID_CELL_CONSISTENCY_UPDATER_CORE_MACROS_SVH

// same-cycle implication
`define GCCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gccu_pkg.sv @@
// ----------------------------------------------------------------------------
// gccu_pkg
// shared types and constants of the grid cell consistency updater
// ----------------------------------------------------------------------------
`default_nettype none

package gccu_pkg;

  localparam int GRID_CELLS   = 65536;
  localparam int COUNTER_BITS = 8;

  localparam int IDX_W   = 16;
  localparam int PIX_W   = 8;
  localparam int CLS_W   = 3;
  localparam int THR_W   = 8;
  localparam int ADDR_W  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int CNT_W   = COUNTER_BITS;
  localparam int SUM_W   = ((CNT_W > THR_W) ? CNT_W : THR_W) + 1;
  localparam int WORD_W  = 2 * CNT_W + CLS_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CLS_W-1:0] CLS_UNKNOWN      = 3'd0;
  localparam logic [CLS_W-1:0] CLS_STATIC       = 3'd1;
  localparam logic [CLS_W-1:0] CLS_FREE         = 3'd2;
  localparam logic [CLS_W-1:0] CLS_INCONSISTENT = 3'd3;
  localparam logic [CLS_W-1:0] CLS_DYNAMIC      = 3'd4;

  localparam logic [1:0] REG_HIT_THR  = 2'd0;
  localparam logic [1:0] REG_MISS_THR = 2'd1;
  localparam logic [1:0] REG_OBJ_MASK = 2'd2;

  localparam logic [THR_W-1:0] HIT_THR_RST  = 8'd8;
  localparam logic [THR_W-1:0] MISS_THR_RST = 8'd8;
  localparam logic [PIX_W-1:0] OBJ_MASK_RST = 8'd1;

  typedef struct packed {
    logic [THR_W-1:0] hit_threshold;
    logic [THR_W-1:0] miss_threshold;
    logic [PIX_W-1:0] object_hit_mask;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              read;
    logic              commit;
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/gccu_if.sv @@
// ----------------------------------------------------------------------------
// gccu channel interfaces
// valid/ready channels for observation items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface gccu_in_if;
  logic                       valid;
  logic                       ready;
  logic [gccu_pkg::IDX_W-1:0] cell_index;
  logic [gccu_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, cell_index, pixel_value, input ready);
  modport sink   (input valid, cell_index, pixel_value, output ready);
endinterface

interface gccu_out_if;
  logic                       valid;
  logic                       ready;
  logic [gccu_pkg::CLS_W-1:0] cell_class;
  logic                       hit_saturated;
  logic                       miss_saturated;

  modport source (output valid, cell_class, hit_saturated, miss_saturated, input ready);
  modport sink   (input valid, cell_class, hit_saturated, miss_saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/grid_cell_consistency_updater_core.sv @@
// flow: an accepted item is captured, its cell read, then updated and written
//   back in a read-modify-write of the cell store, with the result registered;
//   the commit waits while out_valid is stalled, and in_ready stays low until it is done
// reset: synchronous active-low rst_n; afterwards a clearing pass writes all
//   65536 cells, one per cycle, with in_ready low; config writes still taken
// ----------------------------------------------------------------------------
// grid_cell_consistency_updater_core
// per-cell hit/miss counting and class tracking over a cleared grid store
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_consistency_updater_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  gccu_in_if.sink                           in_ch,
  gccu_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gccu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gccu_pkg::PDATA_W-1:0] pwdata,
  output logic      [gccu_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import gccu_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  gccu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gccu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  gccu_dpath u_dpath (
    .clk                (clk),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_cell_index      (in_ch.cell_index),
    .in_pixel_value     (in_ch.pixel_value),
    .out_cell_class     (out_ch.cell_class),
    .out_hit_saturated  (out_ch.hit_saturated),
    .out_miss_saturated (out_ch.miss_saturated)
  );

endmodule

`default_nettype wire

@@ rtl/gccu_regs.sv @@
// ----------------------------------------------------------------------------
// gccu_regs
// apb configuration registers: thresholds and object hit mask
// ----------------------------------------------------------------------------
`default_nettype none

module gccu_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gccu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gccu_pkg::PDATA_W-1:0] pwdata,
  output logic      [gccu_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output gccu_pkg::cfg_t                    cfg
);
  import gccu_pkg::*;

  logic [THR_W-1:0] hit_thr_r;
  logic [THR_W-1:0] miss_thr_r;
  logic [PIX_W-1:0] obj_mask_r;
  logic [1:0]       reg_sel;
  logic             wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_thr_r  <= HIT_THR_RST;
      miss_thr_r <= MISS_THR_RST;
      obj_mask_r <= OBJ_MASK_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HIT_THR:  hit_thr_r  <= pwdata[THR_W-1:0];
        REG_MISS_THR: miss_thr_r <= pwdata[THR_W-1:0];
        REG_OBJ_MASK: obj_mask_r <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HIT_THR:  prdata = PDATA_W'(hit_thr_r);
      REG_MISS_THR: prdata = PDATA_W'(miss_thr_r);
      REG_OBJ_MASK: prdata = PDATA_W'(obj_mask_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.hit_threshold   = hit_thr_r;
  assign cfg.miss_threshold  = miss_thr_r;
  assign cfg.object_hit_mask = obj_mask_r;

endmodule

`default_nettype wire

@@ rtl/gccu_ctrl.sv @@
// ----------------------------------------------------------------------------
// gccu_ctrl
// sequencer: store clearing pass, item capture, read, update and commit
// ----------------------------------------------------------------------------
`default_nettype none

module gccu_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output gccu_pkg::cmd_t  cmd
);
  import gccu_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CALC  = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_CELLS - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              can_commit;

  assign can_commit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.clear_addr = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear    = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (can_commit) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/gccu_dpath.sv @@
// ----------------------------------------------------------------------------
// gccu_dpath
// cell store, counter update with clamping, class transition, result register
// ----------------------------------------------------------------------------
`default_nettype none

module gccu_dpath (
  input  wire logic                       clk,
  input  wire gccu_pkg::cmd_t             cmd,
  input  wire gccu_pkg::cfg_t             cfg,
  input  wire logic [gccu_pkg::IDX_W-1:0] in_cell_index,
  input  wire logic [gccu_pkg::PIX_W-1:0] in_pixel_value,
  output logic      [gccu_pkg::CLS_W-1:0] out_cell_class,
  output logic                            out_hit_saturated,
  output logic                            out_miss_saturated
);
  import gccu_pkg::*;

  localparam logic [IDX_W:0]   IDX_LIMIT = (IDX_W + 1)'(GRID_CELLS);
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((1 << CNT_W) - 1);

  logic [WORD_W-1:0] mem [GRID_CELLS];

  logic [IDX_W-1:0]  idx_r;
  logic [PIX_W-1:0]  pix_r;
  logic [WORD_W-1:0] rd_r;
  logic [CLS_W-1:0]  cls_r;
  logic              hit_sat_r;
  logic              miss_sat_r;

  logic [CNT_W-1:0]  hit_cnt, miss_cnt;
  logic [CLS_W-1:0]  cls_old;
  logic              is_hit, obj_hit, oog;
  logic [SUM_W-1:0]  hit_inc, miss_inc, hit_clamp, miss_clamp;
  logic              hit_sat, miss_sat;
  logic [CNT_W-1:0]  hit_new, miss_new;
  logic [CLS_W-1:0]  cls_new;
  logic [WORD_W-1:0] wr_word;

  assign {hit_cnt, miss_cnt, cls_old} = rd_r;
  assign is_hit  = |pix_r;
  assign obj_hit = is_hit & |(pix_r & cfg.object_hit_mask);
  assign oog     = {1'b0, idx_r} >= IDX_LIMIT;

  // increment, clamp to threshold, then to counter range
  always_comb begin
    hit_inc    = SUM_W'(hit_cnt) + 1'b1;
    miss_inc   = SUM_W'(miss_cnt) + 1'b1;
    hit_sat    = is_hit && (hit_inc >= SUM_W'(cfg.hit_threshold));
    miss_sat   = !is_hit && (miss_inc >= SUM_W'(cfg.miss_threshold));
    hit_clamp  = hit_sat ? SUM_W'(cfg.hit_threshold) : hit_inc;
    miss_clamp = miss_sat ? SUM_W'(cfg.miss_threshold) : miss_inc;
    if (hit_clamp > COUNT_MAX) begin
      hit_clamp = COUNT_MAX;
    end
    if (miss_clamp > COUNT_MAX) begin
      miss_clamp = COUNT_MAX;
    end
    hit_new  = is_hit ? hit_clamp[CNT_W-1:0] : hit_cnt;
    miss_new = is_hit ? miss_cnt : miss_clamp[CNT_W-1:0];
  end

  always_comb begin
    cls_new = cls_old;
    case (cls_old)
      CLS_UNKNOWN: begin
        if (hit_sat) begin
          cls_new = CLS_STATIC;
        end else if (miss_sat) begin
          cls_new = (|hit_new) ? CLS_INCONSISTENT : CLS_FREE;
        end
      end
      CLS_STATIC: begin
        if (miss_sat) begin
          cls_new = CLS_INCONSISTENT;
        end
      end
      CLS_FREE: begin
        if (|hit_new) begin
          cls_new = CLS_INCONSISTENT;
        end
      end
      CLS_INCONSISTENT: begin
        if (hit_sat) begin
          cls_new = CLS_STATIC;
        end else if (obj_hit) begin
          cls_new = CLS_DYNAMIC;
        end
      end
      default: cls_new = cls_old;
    endcase
  end

  assign wr_word = {hit_new, miss_new, cls_new};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_cell_index;
      pix_r <= in_pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[cmd.clear_addr] <= '0;
    end else if (cmd.commit && !oog) begin
      mem[idx_r[ADDR_W-1:0]] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cls_r      <= oog ? CLS_UNKNOWN : cls_new;
      hit_sat_r  <= !oog && hit_sat;
      miss_sat_r <= !oog && miss_sat;
    end
  end

  assign out_cell_class     = cls_r;
  assign out_hit_saturated  = hit_sat_r;
  assign out_miss_saturated = miss_sat_r;

endmodule

`default_nettype wire

@@ rtl/gccu_checker.sv @@
// ----------------------------------------------------------------------------
// gccu_checker
// port-level assertions for the grid cell consistency updater
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_cell_consistency_updater_core_macros.svh"

module gccu_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [gccu_pkg::CLS_W-1:0] out_cell_class,
  input wire logic                       out_hit_saturated,
  input wire logic                       out_miss_saturated
);
  import gccu_pkg::*;

  `GCCU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `GCCU_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "item taken while busy")
  `GCCU_ASSERT_NOW(a_class_range, out_valid, out_cell_class <= CLS_DYNAMIC, "bad class code")
  `GCCU_ASSERT_NOW(a_one_sat, out_valid, !(out_hit_saturated && out_miss_saturated),
    "both counters saturated")

endmodule

bind grid_cell_consistency_updater_core gccu_checker u_gccu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_cell_class     (out_ch.cell_class),
  .out_hit_saturated  (out_ch.hit_saturated),
  .out_miss_saturated (out_ch.miss_saturated)
);

`default_nettype wire
